### rtl/humidity_temp_frame_decoder_core_assert.svh
// Assertion macros for the humidity/temperature frame decoder.
// Expects a clock named clk and a synchronous reset named rst in scope.
`ifndef HUMIDITY_TEMP_FRAME_DECODER_CORE_ASSERT_SVH
`define HUMIDITY_TEMP_FRAME_DECODER_CORE_ASSERT_SVH

// Same-cycle implication.
`define HTFD_ASSERT_SAME(label, ante, cons) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
    else $error("htfd assertion failed");

// Next-cycle implication.
`define HTFD_ASSERT_NEXT(label, ante, cons) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
    else $error("htfd assertion failed");

`endif

### rtl/htfd_pkg.sv
// Shared types, constants and the CRC-8 step for the frame decoder.
// No dependencies.
package htfd_pkg;

  localparam logic [2:0] POS_STATUS = 3'd0;
  localparam logic [2:0] POS_HUM_HI = 3'd1;
  localparam logic [2:0] POS_HUM_MID = 3'd2;
  localparam logic [2:0] POS_SPLIT = 3'd3;
  localparam logic [2:0] POS_TEMP_MID = 3'd4;
  localparam logic [2:0] POS_TEMP_LO = 3'd5;
  localparam logic [2:0] POS_CRC = 3'd6;
  localparam logic [2:0] POS_IDLE = 3'd7;

  localparam logic [7:0] CRC_INIT = 8'hFF;
  localparam logic [7:0] CRC_POLY = 8'h31;

  localparam logic [9:0] HUM_SCALE = 10'd1000;
  localparam logic [10:0] TEMP_SCALE = 11'd2000;
  localparam logic [11:0] TEMP_OFFSET = 12'd500;

  typedef enum logic [1:0] {
    STATUS_VALID   = 2'd0,
    STATUS_CRC_ERR = 2'd1,
    STATUS_BUSY    = 2'd2
  } htfd_status_t;

  typedef struct packed {
    logic [7:0] crc_calc;
    logic [7:0] crc_rx;
    logic busy;
    logic [19:0] hum_raw;
    logic [19:0] temp_raw;
  } htfd_frame_t;

  typedef struct packed {
    htfd_status_t status;
    logic [9:0] hum_tenths;
    logic signed [11:0] temp_tenths;
  } htfd_result_t;

  function automatic logic [7:0] crc8_update(input logic [7:0] crc, input logic [7:0] data);
    logic [7:0] c;
    c = crc ^ data;
    for (int k = 0; k < 8; k++) begin
      c = c[7] ? ({c[6:0], 1'b0} ^ CRC_POLY) : {c[6:0], 1'b0};
    end
    return c;
  endfunction

endpackage

### rtl/htfd_collect.sv
// Frame byte tracker: position, running CRC-8 and raw field capture.
// Depends on htfd_pkg.
module htfd_collect import htfd_pkg::*; (
  input  logic        clk,
  input  logic        rst,
  input  logic        accept,
  input  logic [7:0]  rx_byte,
  input  logic        frame_start,
  output logic        frame_end,
  output htfd_frame_t frame
);

  logic [2:0] byte_position;
  logic [2:0] byte_position_next;
  logic [7:0] crc_accumulator;
  logic [7:0] crc_accumulator_next;
  logic [19:0] humidity_raw;
  logic [19:0] humidity_raw_next;
  logic [19:0] temperature_raw;
  logic [19:0] temperature_raw_next;
  logic busy_seen;
  logic busy_seen_next;
  logic [2:0] pos_eff;
  logic active;

  assign pos_eff = frame_start ? POS_STATUS : byte_position;
  assign active = accept && (frame_start || (byte_position != POS_IDLE));

  always_comb begin
    byte_position_next = byte_position;
    crc_accumulator_next = crc_accumulator;
    humidity_raw_next = humidity_raw;
    temperature_raw_next = temperature_raw;
    busy_seen_next = busy_seen;
    frame_end = 1'b0;
    if (active) begin
      byte_position_next = pos_eff + 3'd1;
      case (pos_eff)
        POS_STATUS: begin
          crc_accumulator_next = crc8_update(CRC_INIT, rx_byte);
          busy_seen_next = rx_byte[7];
          humidity_raw_next = '0;
          temperature_raw_next = '0;
        end
        POS_HUM_HI: begin
          crc_accumulator_next = crc8_update(crc_accumulator, rx_byte);
          humidity_raw_next = {rx_byte, 12'd0};
        end
        POS_HUM_MID: begin
          crc_accumulator_next = crc8_update(crc_accumulator, rx_byte);
          humidity_raw_next[11:4] = rx_byte;
        end
        POS_SPLIT: begin
          crc_accumulator_next = crc8_update(crc_accumulator, rx_byte);
          humidity_raw_next[3:0] = rx_byte[7:4];
          temperature_raw_next = {rx_byte[3:0], 16'd0};
        end
        POS_TEMP_MID: begin
          crc_accumulator_next = crc8_update(crc_accumulator, rx_byte);
          temperature_raw_next[15:8] = rx_byte;
        end
        POS_TEMP_LO: begin
          crc_accumulator_next = crc8_update(crc_accumulator, rx_byte);
          temperature_raw_next[7:0] = rx_byte;
        end
        default: begin
          frame_end = 1'b1;
          byte_position_next = POS_IDLE;
        end
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      byte_position <= POS_IDLE;
      crc_accumulator <= CRC_INIT;
      humidity_raw <= '0;
      temperature_raw <= '0;
      busy_seen <= 1'b0;
    end else begin
      byte_position <= byte_position_next;
      crc_accumulator <= crc_accumulator_next;
      humidity_raw <= humidity_raw_next;
      temperature_raw <= temperature_raw_next;
      busy_seen <= busy_seen_next;
    end
  end

  assign frame.crc_calc = crc_accumulator;
  assign frame.crc_rx = rx_byte;
  assign frame.busy = busy_seen;
  assign frame.hum_raw = humidity_raw;
  assign frame.temp_raw = temperature_raw;

endmodule

### rtl/htfd_convert.sv
// Frame check and unit conversion: status priority and scaled readings.
// Depends on htfd_pkg.
module htfd_convert import htfd_pkg::*; (
  input  htfd_frame_t  frame,
  output htfd_result_t result
);

  logic [29:0] hum_prod;
  logic [30:0] temp_prod;
  htfd_status_t status;

  assign hum_prod = 30'(frame.hum_raw) * 30'(HUM_SCALE);
  assign temp_prod = 31'(frame.temp_raw) * 31'(TEMP_SCALE);

  always_comb begin
    if (frame.crc_calc != frame.crc_rx) begin
      status = STATUS_CRC_ERR;
    end else if (frame.busy) begin
      status = STATUS_BUSY;
    end else begin
      status = STATUS_VALID;
    end
  end

  always_comb begin
    result.status = status;
    result.hum_tenths = '0;
    result.temp_tenths = '0;
    if (status == STATUS_VALID) begin
      result.hum_tenths = hum_prod[29:20];
      result.temp_tenths = $signed({1'b0, temp_prod[30:20]} - TEMP_OFFSET);
    end
  end

endmodule

### rtl/htfd_skid.sv
// Output register with one skid entry for the result channel.
// Depends on htfd_pkg and humidity_temp_frame_decoder_core_assert.svh.
`include "humidity_temp_frame_decoder_core_assert.svh"

module htfd_skid import htfd_pkg::*; (
  input  logic         clk,
  input  logic         rst,
  input  logic         push,
  input  htfd_result_t push_data,
  output logic         full,
  output logic         out_valid,
  input  logic         out_stall,
  output htfd_result_t out_data
);

  logic skid_valid;
  htfd_result_t skid_data;
  logic out_free;

  assign out_free = !out_valid || !out_stall;
  assign full = skid_valid;

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
      skid_valid <= 1'b0;
    end else if (out_free) begin
      if (skid_valid) begin
        out_valid <= 1'b1;
        out_data <= skid_data;
        skid_valid <= 1'b0;
      end else begin
        out_valid <= push;
        if (push) begin
          out_data <= push_data;
        end
      end
    end else if (push) begin
      skid_valid <= 1'b1;
      skid_data <= push_data;
    end
  end

  `HTFD_ASSERT_SAME(a_skid_behind_out, skid_valid, out_valid)
  `HTFD_ASSERT_SAME(a_no_push_when_full, push, !skid_valid)
  `HTFD_ASSERT_NEXT(a_blocked_push_held, push && out_valid && out_stall, skid_valid)

endmodule

### rtl/humidity_temp_frame_decoder_core.sv
// Frame byte 6 registers its result at the output, or in the skid entry while stalled.
// Throughput: one byte per cycle unless stalled; CRC-8 step, capture, scaling: single pass.
// in_stall rises only while the skid entry holds a result behind a stalled output.
// Reset (rst, synchronous, active high): idle awaiting frame_start, CRC at 0xFF, no result.
// Depends on htfd_pkg, htfd_collect, htfd_convert, htfd_skid.
module humidity_temp_frame_decoder_core import htfd_pkg::*; (
  input  logic               clk,
  input  logic               rst,
  input  logic               in_valid,
  output logic               in_stall,
  input  logic [7:0]         rx_byte,
  input  logic               frame_start,
  output logic               out_valid,
  input  logic               out_stall,
  output logic [1:0]         frame_status,
  output logic [9:0]         humidity_tenths,
  output logic signed [11:0] temperature_tenths
);

  logic accept;
  logic frame_end;
  logic full;
  htfd_frame_t frame;
  htfd_result_t result;
  htfd_result_t out_data;

  assign in_stall = full;
  assign accept = in_valid && !full;

  htfd_collect u_collect (
    .clk         (clk),
    .rst         (rst),
    .accept      (accept),
    .rx_byte     (rx_byte),
    .frame_start (frame_start),
    .frame_end   (frame_end),
    .frame       (frame)
  );

  htfd_convert u_convert (
    .frame  (frame),
    .result (result)
  );

  htfd_skid u_skid (
    .clk       (clk),
    .rst       (rst),
    .push      (frame_end),
    .push_data (result),
    .full      (full),
    .out_valid (out_valid),
    .out_stall (out_stall),
    .out_data  (out_data)
  );

  assign frame_status = out_data.status;
  assign humidity_tenths = out_data.hum_tenths;
  assign temperature_tenths = out_data.temp_tenths;

endmodule
